>>> src/icc_pkg.sv
// ----------------------------------------------------------------------------
// icc_pkg
// shared types, keyword tables and character codes of the command classifier
// ----------------------------------------------------------------------------
package icc_pkg;

   // longest command token that is compared, in bytes
   localparam int MAX_COMMAND_CHARS = 31;
   localparam int POS_W = $clog2(MAX_COMMAND_CHARS + 1);

   localparam int NUM_KEYWORDS = 17;
   localparam int KW_SLOTS = 8;

   typedef logic [7:0] char_type;

   localparam char_type CHAR_COLON = 8'h3A;
   localparam char_type CHAR_SPACE = 8'h20;
   localparam char_type CHAR_NUL = 8'h00;

   typedef enum logic [4:0] {
      KIND_INVALID     = 5'd0,
      KIND_PRIVMSG     = 5'd1,
      KIND_NOTICE      = 5'd2,
      KIND_MODE        = 5'd3,
      KIND_JOIN        = 5'd4,
      KIND_PART        = 5'd5,
      KIND_PING        = 5'd6,
      KIND_PONG        = 5'd7,
      KIND_NICK        = 5'd8,
      KIND_QUIT        = 5'd9,
      KIND_KICK        = 5'd10,
      KIND_KILL        = 5'd11,
      KIND_INVITE      = 5'd12,
      KIND_TOPIC       = 5'd13,
      KIND_TOPICORIGIN = 5'd14,
      KIND_NAMES       = 5'd15,
      KIND_UNKNOWN     = 5'd16
   } kind_type;

   typedef enum logic [1:0] {
      PH_EXPECT_COLON = 2'd0,
      PH_PREFIX       = 2'd1,
      PH_COMMAND      = 2'd2,
      PH_CLOSED       = 2'd3
   } phase_type;

   typedef logic [NUM_KEYWORDS-1:0] hits_type;
   typedef logic [POS_W-1:0] pos_type;

   // one byte handed from the input register to the parser
   typedef struct packed {
      logic     take;
      char_type data;
      logic     last;
   } icc_byte_type;

   // per-line parse state
   typedef struct packed {
      phase_type phase;
      pos_type   pos;
      hits_type  hits;
      logic      invalid;
   } icc_line_state_type;

   localparam char_type KW_TEXT [NUM_KEYWORDS][KW_SLOTS] = '{
      '{"P", "R", "I", "V", "M", "S", "G", CHAR_NUL},
      '{"N", "O", "T", "I", "C", "E", CHAR_NUL, CHAR_NUL},
      '{"M", "O", "D", "E", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"J", "O", "I", "N", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"P", "A", "R", "T", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"P", "I", "N", "G", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"P", "O", "N", "G", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"N", "I", "C", "K", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"Q", "U", "I", "T", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"K", "I", "C", "K", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"K", "I", "L", "L", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"I", "N", "V", "I", "T", "E", CHAR_NUL, CHAR_NUL},
      '{"3", "3", "2", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"T", "O", "P", "I", "C", CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"3", "3", "3", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"3", "5", "3", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"N", "A", "M", "E", "S", CHAR_NUL, CHAR_NUL, CHAR_NUL}
   };

   localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
      3'd7, 3'd6, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd6,
      3'd3, 3'd5, 3'd3, 3'd3, 3'd5
   };

   localparam kind_type KW_KIND [NUM_KEYWORDS] = '{
      KIND_PRIVMSG, KIND_NOTICE, KIND_MODE, KIND_JOIN, KIND_PART, KIND_PING,
      KIND_PONG, KIND_NICK, KIND_QUIT, KIND_KICK, KIND_KILL, KIND_INVITE,
      KIND_TOPIC, KIND_TOPIC, KIND_TOPICORIGIN, KIND_NAMES, KIND_NAMES
   };

endpackage

>>> src/irc_command_classifier.sv
// ----------------------------------------------------------------------------
// irc_command_classifier
// classifies one irc line, fed a byte per word, into a message kind code
// ----------------------------------------------------------------------------
// Takes one byte of an irc line per cycle while req_stall is low, with
// req_line_end on the last byte, and gives one rsp_message_kind word per
// line. A line must open with ':' and have a space after its prefix, else it
// is invalid (0). The command token after that space (up to a space, a zero
// byte, the line end or the first MAX_COMMAND_CHARS bytes) is matched against
// the keyword list as it streams in; the final byte produces the kind, or
// unknown (16) for no match or an empty token. Throughput is one byte per
// cycle, save for a last byte held by a stalled result: the keyword flags
// of all keywords update in parallel between the input register and the
// parse state. The kind passes two register stages: input register,
// result register. A stalled result holds only the last byte of the next
// line back; bytes before it keep flowing. No clearing pass after reset.
module irc_command_classifier (
   input  logic                 clock,
   input  logic                 reset,
   // byte stream in
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_line_byte,
   input  logic                 req_line_end,
   // kind out
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [4:0]           rsp_message_kind
);
   import icc_pkg::*;

   // input register
   logic      in_valid_ff;
   logic      in_valid_in;
   char_type  in_byte_ff;
   logic      in_last_ff;

   // result register
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   kind_type  kind_ff;

   logic         out_free;
   logic         advance;
   logic         req_take;
   icc_byte_type byte_word;
   kind_type     line_kind;

   // a byte leaves the input register unless it ends a line and the result
   // register is still full
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;

   assign in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_line_byte;
         in_last_ff <= req_line_end;
      end
   end

   assign byte_word = '{take: advance, data: in_byte_ff, last: in_last_ff};

   icc_line_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .byte_in (byte_word),
      .kind    (line_kind)
   );

   // a line's kind is loaded when its last byte advances
   always_comb begin
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         kind_ff <= line_kind;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_message_kind = kind_ff;

`ifndef SYNTH
   // last byte of a line waits while the previous result is still stalled
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_last_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("line end advanced over a stalled result");

   // a byte that does not end a line never creates a result word
   assert property (@(posedge clock) disable iff (reset)
      (advance && !in_last_ff) |=> (rsp_valid_ff == $past(rsp_valid_ff && rsp_stall)))
      else $error("result word without line end");

   // both stages come out of reset empty
   assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !in_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

>>> src/icc_keyword_match.sv
// ----------------------------------------------------------------------------
// icc_keyword_match
// narrows the keyword hit flags by one command byte, all keywords in parallel
// ----------------------------------------------------------------------------
module icc_keyword_match (
   input  icc_pkg::hits_type hits,
   input  icc_pkg::pos_type  pos,
   input  icc_pkg::char_type data,
   output icc_pkg::hits_type hits_upd
);
   import icc_pkg::*;

   always_comb begin
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         hits_upd[k] = hits[k] && (pos < POS_W'(KW_LEN[k]))
                       && (KW_TEXT[k][pos[2:0]] == data);
      end
   end

endmodule

>>> src/icc_classify.sv
// ----------------------------------------------------------------------------
// icc_classify
// turns the line state after its last byte into a message kind code
// ----------------------------------------------------------------------------
module icc_classify (
   input  icc_pkg::icc_line_state_type line_state,
   output icc_pkg::kind_type           kind
);
   import icc_pkg::*;

   logic [NUM_KEYWORDS-1:0] full_hit;

   always_comb begin
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         full_hit[k] = line_state.hits[k] && (line_state.pos == POS_W'(KW_LEN[k]));
      end
   end

   // lowest matching keyword wins
   always_comb begin
      kind = KIND_UNKNOWN;
      for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
         if (full_hit[k]) begin
            kind = KW_KIND[k];
         end
      end
      if (line_state.invalid || line_state.phase == PH_EXPECT_COLON
          || line_state.phase == PH_PREFIX) begin
         kind = KIND_INVALID;
      end
   end

endmodule

>>> src/icc_line_parser.sv
// ----------------------------------------------------------------------------
// icc_line_parser
// per-line parse state machine; gives the kind of the line on its last byte
// ----------------------------------------------------------------------------
module icc_line_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  icc_pkg::icc_byte_type byte_in,
   output icc_pkg::kind_type    kind
);
   import icc_pkg::*;

   icc_line_state_type state_ff;
   icc_line_state_type state_upd;
   icc_line_state_type state_in;
   hits_type           hits_upd;
   logic [POS_W:0]     pos_plus;

   localparam icc_line_state_type LINE_CLEAR = '{
      phase:   PH_EXPECT_COLON,
      pos:     '0,
      hits:    '1,
      invalid: 1'b0
   };

   icc_keyword_match u_match (
      .hits     (state_ff.hits),
      .pos      (state_ff.pos),
      .data     (byte_in.data),
      .hits_upd (hits_upd)
   );

   assign pos_plus = {1'b0, state_ff.pos} + (POS_W + 1)'(1);

   always_comb begin
      state_upd = state_ff;
      case (state_ff.phase)
         PH_EXPECT_COLON: begin
            if (byte_in.data == CHAR_COLON) begin
               state_upd.phase = PH_PREFIX;
            end else begin
               state_upd.invalid = 1'b1;
               state_upd.phase = PH_CLOSED;
            end
         end
         PH_PREFIX: begin
            if (byte_in.data == CHAR_NUL) begin
               state_upd.invalid = 1'b1;
               state_upd.phase = PH_CLOSED;
            end else if (byte_in.data == CHAR_SPACE) begin
               state_upd.phase = PH_COMMAND;
            end
         end
         PH_COMMAND: begin
            if (byte_in.data == CHAR_NUL || byte_in.data == CHAR_SPACE) begin
               state_upd.phase = PH_CLOSED;
            end else begin
               state_upd.hits = hits_upd;
               state_upd.pos = pos_plus[POS_W-1:0];
               if (pos_plus >= (POS_W + 1)'(MAX_COMMAND_CHARS)) begin
                  state_upd.phase = PH_CLOSED;
               end
            end
         end
         default: begin
            state_upd = state_ff;
         end
      endcase

      // rearm after the last byte of a line
      if (!byte_in.take) begin
         state_in = state_ff;
      end else if (byte_in.last) begin
         state_in = LINE_CLEAR;
      end else begin
         state_in = state_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LINE_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   icc_classify u_classify (
      .line_state (state_upd),
      .kind       (kind)
   );

endmodule
